// ===== hdl/sfq_pkg.sv =====
// Shared types and codes for the searchable FIFO queue.
// Used by sfq_ram and searchable_fifo_queue; depends on nothing else.
package sfq_pkg;

    // Width of one stored word.
    localparam int WORD_W = 32;

    typedef logic [WORD_W-1:0] word_t;

    // Value returned by a dequeue from an empty queue.
    localparam word_t EMPTY_WORD = '1;

    // Command codes carried on the cmd field.
    typedef enum logic [1:0] {
        CMD_ENQUEUE = 2'd0,
        CMD_DEQUEUE = 2'd1,
        CMD_UPDATE  = 2'd2,
        CMD_SEARCH  = 2'd3
    } cmd_t;

    // Status codes carried on the status field.
    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_EMPTY     = 2'd1,
        ST_FULL      = 2'd2,
        ST_NOT_FOUND = 2'd3
    } status_t;

endpackage

// ===== hdl/searchable_fifo_queue.sv =====
// Searchable FIFO queue top level: a ring of DEPTH signed words with enqueue, dequeue,
// update of the first match and search; uses sfq_pkg and the sfq_ram ring storage.
// One item at a time: the input stalls until the result is handed off; a search or update
// reads entries from the head, one ring read per cycle, until a match or the last entry.
// Reset clears head, count and output valid, not storage.
module searchable_fifo_queue #(
    parameter int DEPTH = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [1:0]         cmd,
    input  logic signed [31:0] value,
    input  logic signed [31:0] new_value,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [31:0] read_value,
    output logic               found,
    output logic [1:0]         status
);

    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int SUM_W  = ADDR_W + 1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DEQ,
        S_SCAN,
        S_DONE
    } state_t;

    state_t              state_reg, state_next;
    logic [ADDR_W-1:0]   head_reg, head_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [ADDR_W-1:0]   pos_reg, pos_next;
    logic [ADDR_W-1:0]   cmp_pos_reg, cmp_pos_next;
    logic [CNT_W-1:0]    issued_reg, issued_next;
    logic                out_valid_reg, out_valid_next;

    sfq_pkg::cmd_t       cmd_reg;
    sfq_pkg::word_t      key_reg;
    sfq_pkg::word_t      new_reg;
    sfq_pkg::word_t      res_value_reg, res_value_next;
    logic                res_found_reg, res_found_next;
    sfq_pkg::status_t    res_status_reg, res_status_next;
    sfq_pkg::word_t      out_value_reg;
    logic                out_found_reg;
    sfq_pkg::status_t    out_status_reg;

    logic                in_xfer;
    logic                out_free;
    logic                out_load;
    sfq_pkg::cmd_t       in_cmd;
    logic [SUM_W-1:0]    tail_sum;
    logic [ADDR_W-1:0]   tail_pos;
    logic                wr_en;
    logic [ADDR_W-1:0]   wr_addr;
    sfq_pkg::word_t      wr_data;
    logic [ADDR_W-1:0]   rd_addr;
    sfq_pkg::word_t      rd_data;

    // Advance a ring position, wrapping from the last entry back to zero.
    function automatic logic [ADDR_W-1:0] ring_next(input logic [ADDR_W-1:0] p);
        logic [ADDR_W-1:0] r;
        if (p == ADDR_W'(DEPTH - 1))
        begin
            r = '0;
        end
        else
        begin
            r = p + 1'b1;
        end
        return r;
    endfunction

    assign in_xfer  = in_valid && !in_stall;
    assign in_stall = (state_reg != S_IDLE);
    assign out_free = !out_valid_reg || !out_stall;
    assign out_load = (state_reg == S_DONE) && out_free;
    assign in_cmd   = sfq_pkg::cmd_t'(cmd);

    // Tail position is head plus count, folded back into the ring.
    always_comb
    begin
        tail_sum = SUM_W'(head_reg) + SUM_W'(count_reg);
        if (tail_sum >= SUM_W'(DEPTH))
        begin
            tail_sum = tail_sum - SUM_W'(DEPTH);
        end
        tail_pos = tail_sum[ADDR_W-1:0];
    end

    // The storage is read at the head, except while scanning.
    assign rd_addr = (state_reg == S_SCAN) ? pos_reg : head_reg;

    // Sequencer next-state and result logic.
    always_comb
    begin
        state_next      = state_reg;
        head_next       = head_reg;
        count_next      = count_reg;
        pos_next        = pos_reg;
        cmp_pos_next    = cmp_pos_reg;
        issued_next     = issued_reg;
        res_value_next  = res_value_reg;
        res_found_next  = res_found_reg;
        res_status_next = res_status_reg;
        wr_en           = 1'b0;
        wr_addr         = tail_pos;
        wr_data         = value;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    res_value_next  = '0;
                    res_found_next  = 1'b0;
                    res_status_next = sfq_pkg::ST_OK;
                    unique case (in_cmd) inside
                        sfq_pkg::CMD_ENQUEUE:
                        begin
                            if (count_reg == CNT_W'(DEPTH))
                            begin
                                res_status_next = sfq_pkg::ST_FULL;
                            end
                            else
                            begin
                                wr_en      = 1'b1;
                                count_next = count_reg + 1'b1;
                            end
                            state_next = S_DONE;
                        end
                        sfq_pkg::CMD_DEQUEUE:
                        begin
                            if (count_reg == '0)
                            begin
                                res_value_next  = sfq_pkg::EMPTY_WORD;
                                res_status_next = sfq_pkg::ST_EMPTY;
                                state_next      = S_DONE;
                            end
                            else
                            begin
                                state_next = S_DEQ;
                            end
                        end
                        sfq_pkg::CMD_UPDATE, sfq_pkg::CMD_SEARCH:
                        begin
                            if (count_reg == '0)
                            begin
                                if (in_cmd == sfq_pkg::CMD_UPDATE)
                                begin
                                    res_status_next = sfq_pkg::ST_NOT_FOUND;
                                end
                                state_next = S_DONE;
                            end
                            else
                            begin
                                // The head read goes out this cycle.
                                cmp_pos_next = head_reg;
                                pos_next     = ring_next(head_reg);
                                issued_next  = CNT_W'(1);
                                state_next   = S_SCAN;
                            end
                        end
                        default:
                        begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end

            S_DEQ:
            begin
                res_value_next = rd_data;
                head_next      = ring_next(head_reg);
                count_next     = count_reg - 1'b1;
                state_next     = S_DONE;
            end

            S_SCAN:
            begin
                // Read data belongs to cmp_pos_reg; the next read is issued at pos_reg.
                if (rd_data == key_reg)
                begin
                    res_found_next = 1'b1;
                    if (cmd_reg == sfq_pkg::CMD_UPDATE)
                    begin
                        wr_en   = 1'b1;
                        wr_addr = cmp_pos_reg;
                        wr_data = new_reg;
                    end
                    state_next = S_DONE;
                end
                else if (issued_reg == count_reg)
                begin
                    if (cmd_reg == sfq_pkg::CMD_UPDATE)
                    begin
                        res_status_next = sfq_pkg::ST_NOT_FOUND;
                    end
                    state_next = S_DONE;
                end
                else
                begin
                    cmp_pos_next = pos_reg;
                    pos_next     = ring_next(pos_reg);
                    issued_next  = issued_reg + 1'b1;
                end
            end

            S_DONE:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Output valid follows the result register hand-off.
    always_comb
    begin
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    // State and control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            head_reg      <= '0;
            count_reg     <= '0;
            pos_reg       <= '0;
            cmp_pos_reg   <= '0;
            issued_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            count_reg     <= count_next;
            pos_reg       <= pos_next;
            cmp_pos_reg   <= cmp_pos_next;
            issued_reg    <= issued_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers: captured command, result and output words.
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            cmd_reg <= in_cmd;
            key_reg <= value;
            new_reg <= new_value;
        end
        res_value_reg  <= res_value_next;
        res_found_reg  <= res_found_next;
        res_status_reg <= res_status_next;
        if (out_load)
        begin
            out_value_reg  <= res_value_reg;
            out_found_reg  <= res_found_reg;
            out_status_reg <= res_status_reg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign read_value = out_value_reg;
    assign found      = out_found_reg;
    assign status     = out_status_reg;

    // Ring storage.
    sfq_ram #(
        .DEPTH(DEPTH)
    ) u_ram (
        .clk    (clk),
        .wr_en  (wr_en),
        .wr_addr(wr_addr),
        .wr_data(wr_data),
        .rd_addr(rd_addr),
        .rd_data(rd_data)
    );

    // The entry count never exceeds the ring size.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("entry count exceeds depth");

    // The head index always points inside the ring.
    a_head_bound: assert property (@(posedge clk) disable iff (!rst_n)
        head_reg <= ADDR_W'(DEPTH - 1))
        else $error("head index outside ring");

    // A scan never reads past the valid entries.
    a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN) |-> (issued_reg != '0) && (issued_reg <= count_reg))
        else $error("scan beyond valid entries");

    // An accepted transfer always starts the sequencer.
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer |=> (state_reg != S_IDLE))
        else $error("accepted item did not start work");

    // A new result appears only when the sequencer hands one off.
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_DONE))
        else $error("output valid without finished result");

endmodule

// ===== hdl/sfq_ram.sv =====
// Simple dual-port storage for the queue ring: one write port, one read port
// with registered read data. Depends on sfq_pkg for the word type.
module sfq_ram #(
    parameter int DEPTH = 16,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                clk,
    input  logic                wr_en,
    input  logic [ADDR_W-1:0]   wr_addr,
    input  sfq_pkg::word_t      wr_data,
    input  logic [ADDR_W-1:0]   rd_addr,
    output sfq_pkg::word_t      rd_data
);

    sfq_pkg::word_t mem [DEPTH];
    sfq_pkg::word_t rd_data_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read port; data appears in the cycle after the address.
    always_ff @(posedge clk)
    begin
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule
